// File: sv/tcw_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the text console writer.
package tcw_pkg;

    localparam int DEF_COLUMNS     = 80;
    localparam int DEF_ROWS        = 25;
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam int OPCODE_W = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int OFFSET_W = 11;
    localparam int CELL_W   = CHAR_W + ATTR_W;
    localparam int TAB_STEP = 8;

    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_TEXT_ATTR = '0;

    localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_DEFAULT = 8'h07;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        CMD_PRINT,
        CMD_NEWLINE,
        CMD_RETURN,
        CMD_BACKSPACE,
        CMD_TAB,
        CMD_CLEAR,
        CMD_READ,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [CHAR_W-1:0]  ch;
        logic [INDEX_W-1:0] index;
        logic               in_range;
    } t_cmd;

endpackage

// File: sv/tcw_in_if.sv
`timescale 1ns / 1ps
// Input channel interface: one console command per beat.
interface tcw_in_if
    import tcw_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [CHAR_W-1:0]   char_code;
    logic [INDEX_W-1:0]  cell_index;

    modport source (output valid, output opcode, output char_code, output cell_index,
                    input ready);
    modport sink (input valid, input opcode, input char_code, input cell_index,
                  output ready);
endinterface

// File: sv/tcw_out_if.sv
`timescale 1ns / 1ps
// Output channel interface: one result per beat.
interface tcw_out_if
    import tcw_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] cursor_offset;
    logic [CHAR_W-1:0]   read_char;
    logic [ATTR_W-1:0]   read_attr;

    modport source (output valid, output cursor_offset, output read_char, output read_attr,
                    input ready);
    modport sink (input valid, input cursor_offset, input read_char, input read_attr,
                  output ready);
endinterface

// File: sv/tcw_front.sv
`timescale 1ns / 1ps
// Front end: accepts input beats and classifies them into console commands.
module tcw_front
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tcw_in_if.sink i_in,
    input  logic  i_hold,
    output t_cmd  o_cmd,
    output logic  o_cmd_valid,
    input  logic  i_cmd_ready
);
    localparam int CELLS = ROWS * COLUMNS;

    t_cmd r_cmd;
    t_cmd n_cmd;
    logic r_valid;
    logic accept;

    assign i_in.ready  = !i_hold && (!r_valid || i_cmd_ready);
    assign accept      = i_in.valid && i_in.ready;
    assign o_cmd       = r_cmd;
    assign o_cmd_valid = r_valid;

    always_comb begin
        n_cmd          = '0;
        n_cmd.kind     = CMD_NOP;
        n_cmd.ch       = i_in.char_code;
        n_cmd.index    = i_in.cell_index;
        n_cmd.in_range = 32'(i_in.cell_index) < 32'(CELLS);
        case (t_opcode'(i_in.opcode))
            OP_PUT: begin
                case (i_in.char_code)
                    CH_NEWLINE:   n_cmd.kind = CMD_NEWLINE;
                    CH_RETURN:    n_cmd.kind = CMD_RETURN;
                    CH_BACKSPACE: n_cmd.kind = CMD_BACKSPACE;
                    CH_TAB:       n_cmd.kind = CMD_TAB;
                    default:      n_cmd.kind = CMD_PRINT;
                endcase
            end
            OP_CLEAR: n_cmd.kind = CMD_CLEAR;
            OP_READ:  n_cmd.kind = CMD_READ;
            default:  n_cmd.kind = CMD_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// File: sv/tcw_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
module tcw_queue
    import tcw_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_data,
    input  logic i_pop
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_ready = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_slots[r_rd];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slots[r_wr] <= i_data;
        end
    end

endmodule

// File: sv/tcw_back.sv
`timescale 1ns / 1ps
// Back end: cursor, screen store, scroll and clear passes, and the result register.
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_cmd_valid,
    output logic              o_cmd_pop,
    input  logic [ATTR_W-1:0] i_text_attr,
    tcw_out_if.source         o_out,
    output logic              o_init_busy
);
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int IXW     = (CELL_AW > INDEX_W) ? CELL_AW : INDEX_W;
    localparam int OXW     = (CELL_AW > OFFSET_W) ? CELL_AW : OFFSET_W;

    localparam logic [CELL_AW-1:0] COLS_OFF  = CELL_AW'(COLUMNS);
    localparam logic [CELL_AW-1:0] LAST_BASE = CELL_AW'((ROWS - 1) * COLUMNS);
    localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(CELLS - 1);
    localparam logic [CELL_AW-1:0] COPY_END  = CELL_AW'(CELLS - COLUMNS);
    localparam logic [ROW_W-1:0]   LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]   LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [COL_W:0]     COL_END   = (COL_W + 1)'(COLUMNS);
    localparam logic [COL_W:0]     TAB_LOW   = (COL_W + 1)'(TAB_STEP - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_SCROLL,
        S_READ,
        S_DONE
    } t_state;

    logic [CELL_W-1:0]  r_cells [CELLS];
    logic [CELL_W-1:0]  r_rdata;

    t_state             r_state, n_state;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [CELL_AW-1:0] r_offset, n_offset;
    logic [CELL_AW-1:0] r_ptr, n_ptr;
    logic               r_wv, n_wv;
    logic [CELL_AW-1:0] r_waddr, n_waddr;
    logic               r_wcopy, n_wcopy;
    logic               r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]  r_out_char, n_out_char;
    logic [ATTR_W-1:0]  r_out_attr, n_out_attr;

    logic               pop;
    logic [COL_W:0]     col_inc;
    logic [COL_W:0]     tab_col;
    logic [CELL_AW-1:0] col_ext;
    logic               adv;
    logic               scroll;
    logic [ROW_W-1:0]   cur_row;
    logic [COL_W-1:0]   cur_col;
    logic [CELL_AW-1:0] cur_offset;
    logic [IXW-1:0]     idx_ext;
    logic [CELL_AW-1:0] read_addr;
    logic [OXW-1:0]     off_ext;

    logic               mem_we;
    logic [CELL_AW-1:0] mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic [CELL_AW-1:0] mem_raddr;

    assign pop         = (r_state == S_IDLE) && i_cmd_valid && !r_out_valid;
    assign o_cmd_pop   = pop;
    assign o_init_busy = r_state == S_INIT;
    assign idx_ext     = IXW'(i_cmd.index);
    assign read_addr   = idx_ext[CELL_AW-1:0];
    assign off_ext     = OXW'(r_offset);

    assign o_out.valid         = r_out_valid;
    assign o_out.cursor_offset = off_ext[OFFSET_W-1:0];
    assign o_out.read_char     = r_out_char;
    assign o_out.read_attr     = r_out_attr;

    // Cursor movement for the command at the head of the queue.
    always_comb begin
        col_inc    = {1'b0, r_col} + (COL_W + 1)'(1);
        tab_col    = ({1'b0, r_col} | TAB_LOW) + (COL_W + 1)'(1);
        col_ext    = CELL_AW'(r_col);
        adv        = 1'b0;
        scroll     = 1'b0;
        cur_row    = r_row;
        cur_col    = r_col;
        cur_offset = r_offset;
        case (i_cmd.kind)
            CMD_PRINT: begin
                cur_offset = r_offset + CELL_AW'(1);
                if (col_inc == COL_END) begin
                    adv     = 1'b1;
                    cur_col = '0;
                end else begin
                    cur_col = col_inc[COL_W-1:0];
                end
            end
            CMD_NEWLINE: begin
                adv        = 1'b1;
                cur_col    = '0;
                cur_offset = r_offset - col_ext + COLS_OFF;
            end
            CMD_RETURN: begin
                cur_col    = '0;
                cur_offset = r_offset - col_ext;
            end
            CMD_BACKSPACE: begin
                if (r_col != '0) begin
                    cur_col    = r_col - COL_W'(1);
                    cur_offset = r_offset - CELL_AW'(1);
                end else if (r_row != '0) begin
                    cur_row    = r_row - ROW_W'(1);
                    cur_col    = LAST_COL;
                    cur_offset = r_offset - CELL_AW'(1);
                end
            end
            CMD_TAB: begin
                if (tab_col >= COL_END) begin
                    adv        = 1'b1;
                    cur_col    = '0;
                    cur_offset = r_offset - col_ext + COLS_OFF;
                end else begin
                    cur_col    = tab_col[COL_W-1:0];
                    cur_offset = r_offset - col_ext + CELL_AW'(tab_col);
                end
            end
            default: begin
                adv = 1'b0;
            end
        endcase
        if (adv) begin
            if (r_row == LAST_ROW) begin
                scroll     = 1'b1;
                cur_offset = LAST_BASE;
            end else begin
                cur_row = r_row + ROW_W'(1);
            end
        end
    end

    // Single write port and single read port of the screen store.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = {ATTR_DEFAULT, CH_NUL};
        mem_raddr = r_ptr + COLS_OFF;
        if (r_wv) begin
            mem_we    = 1'b1;
            mem_waddr = r_waddr;
            mem_wdata = r_wcopy ? r_rdata : {ATTR_DEFAULT, CH_BLANK};
        end
        case (r_state)
            S_INIT, S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_IDLE: begin
                mem_raddr = read_addr;
                if (pop && i_cmd.kind == CMD_PRINT) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_offset;
                    mem_wdata = {i_text_attr, i_cmd.ch};
                end else if (pop && i_cmd.kind == CMD_BACKSPACE) begin
                    mem_we    = 1'b1;
                    mem_waddr = cur_offset;
                    mem_wdata = {i_text_attr, CH_BLANK};
                end
            end
            default: begin
                mem_raddr = r_ptr + COLS_OFF;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_cells[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_cells[mem_raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_offset    = r_offset;
        n_ptr       = r_ptr;
        n_wv        = 1'b0;
        n_waddr     = r_ptr;
        n_wcopy     = r_ptr < COPY_END;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_attr  = r_out_attr;
        if (o_out.valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_INIT: begin
                n_ptr = r_ptr + CELL_AW'(1);
                if (r_ptr == LAST_CELL) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (pop) begin
                    case (i_cmd.kind)
                        CMD_CLEAR: begin
                            n_row    = '0;
                            n_col    = '0;
                            n_offset = '0;
                            n_ptr    = '0;
                            n_state  = S_CLEAR;
                        end
                        CMD_READ: begin
                            if (i_cmd.in_range) begin
                                n_state = S_READ;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out_char  = '0;
                                n_out_attr  = '0;
                            end
                        end
                        default: begin
                            n_row    = cur_row;
                            n_col    = cur_col;
                            n_offset = cur_offset;
                            if (scroll) begin
                                n_ptr   = '0;
                                n_state = S_SCROLL;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out_char  = '0;
                                n_out_attr  = '0;
                            end
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                n_ptr = r_ptr + CELL_AW'(1);
                if (r_ptr == LAST_CELL) begin
                    n_ptr       = '0;
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out_char  = '0;
                    n_out_attr  = '0;
                end
            end
            S_SCROLL: begin
                n_wv  = 1'b1;
                n_ptr = r_ptr + CELL_AW'(1);
                if (r_ptr == LAST_CELL) begin
                    n_ptr   = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_out_char  = '0;
                n_out_attr  = '0;
            end
            S_READ: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_out_char  = r_rdata[CHAR_W-1:0];
                n_out_attr  = r_rdata[CELL_W-1:CHAR_W];
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_offset    <= '0;
            r_ptr       <= '0;
            r_wv        <= 1'b0;
            r_waddr     <= '0;
            r_wcopy     <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_char  <= '0;
            r_out_attr  <= '0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_offset    <= n_offset;
            r_ptr       <= n_ptr;
            r_wv        <= n_wv;
            r_waddr     <= n_waddr;
            r_wcopy     <= n_wcopy;
            r_out_valid <= n_out_valid;
            r_out_char  <= n_out_char;
            r_out_attr  <= n_out_attr;
        end
    end

    a_offset_matches_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_offset) == 32'(r_row) * COLUMNS + 32'(r_col))
        else $error("cursor offset disagrees with row and column");

    a_cursor_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < COLUMNS && 32'(r_row) < ROWS)
        else $error("cursor outside the screen");

    a_init_runs_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_INIT |=> r_state != S_INIT)
        else $error("store initialization pass restarted without reset");

    a_no_result_during_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL || r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result presented while a store pass is running");

    a_write_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> 32'(mem_waddr) < CELLS)
        else $error("store write beyond the last cell");

endmodule

// File: sv/text_console_writer_core.sv
`timescale 1ns / 1ps
// Top level of the text console writer: configuration register, front end, queue, back end.
//
// Channel  Direction  Beat contents                          Handshake
// i_in     in         opcode, char_code, cell_index          valid / ready
// o_out    out        cursor_offset, read_char, read_attr    valid / ready
// APB      in/out     text_attr at byte address 0            psel, penable; pready tied high
//
// A put, an unused opcode and an out-of-range read are answered from the idle state of the
// back end; an in-range read passes through the read state, as the read port of the screen
// store is registered. A put that passes the last row runs a scroll pass over the store,
// and a clear runs a clear pass over every cell of the store.
// After reset all ROWS*COLUMNS cells of the store (2000 by default) are filled with
// i_in.ready low; configuration writes are taken throughout.
// The front register and the queue lie ahead of the back end and keep taking beats while
// a result waits on o_out, as long as they have room.
module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS     = DEF_COLUMNS,
    parameter int ROWS        = DEF_ROWS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tcw_in_if.sink                i_in,
    tcw_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    logic [ATTR_W-1:0] r_text_attr;
    logic              init_busy;
    t_cmd              front_cmd;
    logic              front_valid;
    logic              queue_ready;
    t_cmd              queue_cmd;
    logic              queue_valid;
    logic              queue_pop;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TEXT_ATTR) ? APB_DATA_W'(r_text_attr) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr <= ATTR_DEFAULT;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_TEXT_ATTR) begin
            r_text_attr <= pwdata[ATTR_W-1:0];
        end
    end

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_hold      (init_busy),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (queue_ready)
    );

    tcw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_cmd),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_data  (queue_cmd),
        .i_pop   (queue_pop)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_cmd_valid (queue_valid),
        .o_cmd_pop   (queue_pop),
        .i_text_attr (r_text_attr),
        .o_out       (o_out),
        .o_init_busy (init_busy)
    );

endmodule

// File: tb/sv/text_console_writer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the text console writer: screen predictor, scoreboard, drivers.
module text_console_writer_core_tb;
    import tcw_pkg::*;

    localparam int COLS      = DEF_COLUMNS;
    localparam int LINES     = DEF_ROWS;
    localparam int CELLS     = COLS * LINES;
    localparam int INDEX_MAX = 2 ** INDEX_W - 1;
    localparam int PHASE_ITEMS = 630;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OFFSET_W-1:0] cursor_offset;
        logic [CHAR_W-1:0]   read_char;
        logic [ATTR_W-1:0]   read_attr;
    } t_console_result;

    class console_scoreboard;
        logic [CHAR_W-1:0] cell_ch [CELLS];
        logic [ATTR_W-1:0] cell_at [CELLS];
        int row;
        int col;
        logic [ATTR_W-1:0] attr;
        t_console_result awaited [$];
        int errors;
        int puts;
        int reads;
        int clears;
        int unused;
        int scrolls;

        function new();
            home_and_clear();
            attr = ATTR_DEFAULT;
        endfunction

        function void home_and_clear();
            for (int k = 0; k < CELLS; k++) begin
                cell_ch[k] = CH_NUL;
                cell_at[k] = ATTR_DEFAULT;
            end
            row = 0;
            col = 0;
        endfunction

        function void store(int r, int c, logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] at);
            int k;
            k = r * COLS + c;
            if (k < CELLS) begin
                cell_ch[k] = ch;
                cell_at[k] = at;
            end
        endfunction

        function void apply_put(logic [CHAR_W-1:0] ch);
            case (ch)
                CH_NEWLINE: begin
                    col = 0;
                    row++;
                end
                CH_RETURN: begin
                    col = 0;
                end
                CH_BACKSPACE: begin
                    if (col > 0) begin
                        col--;
                    end else if (row > 0) begin
                        row--;
                        col = COLS - 1;
                    end
                    store(row, col, CH_BLANK, attr);
                end
                CH_TAB: begin
                    col = col + TAB_STEP - (col % TAB_STEP);
                    if (col >= COLS) begin
                        col = 0;
                        row++;
                    end
                end
                default: begin
                    store(row, col, ch, attr);
                    col++;
                    if (col >= COLS) begin
                        col = 0;
                        row++;
                    end
                end
            endcase
            if (row >= LINES) begin
                for (int k = 0; k + COLS < CELLS; k++) begin
                    cell_ch[k] = cell_ch[k + COLS];
                    cell_at[k] = cell_at[k + COLS];
                end
                for (int k = CELLS - COLS; k < CELLS; k++) begin
                    cell_ch[k] = CH_BLANK;
                    cell_at[k] = ATTR_DEFAULT;
                end
                row = LINES - 1;
                scrolls++;
            end
        endfunction

        function int cursor();
            return row * COLS + col;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_input(logic [OPCODE_W-1:0] op, logic [CHAR_W-1:0] ch,
                                 logic [INDEX_W-1:0] idx);
            t_console_result r;
            r = '0;
            if (op == OP_PUT) begin
                apply_put(ch);
                puts++;
            end else if (op == OP_CLEAR) begin
                home_and_clear();
                clears++;
            end else if (op == OP_READ) begin
                if (idx < CELLS) begin
                    r.read_char = cell_ch[idx];
                    r.read_attr = cell_at[idx];
                end
                reads++;
            end else begin
                unused++;
            end
            r.cursor_offset = OFFSET_W'(cursor());
            awaited.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [OFFSET_W-1:0] offset, logic [CHAR_W-1:0] ch,
                          logic [ATTR_W-1:0] at);
            t_console_result want;
            if (awaited.size() == 0) begin
                report($sformatf("result beat with nothing expected, offset %0d", offset));
                return;
            end
            want = awaited.pop_front();
            if (offset !== want.cursor_offset)
                report($sformatf("cursor_offset %0d, expected %0d", offset, want.cursor_offset));
            if (ch !== want.read_char)
                report($sformatf("read_char %h, expected %h", ch, want.read_char));
            if (at !== want.read_attr)
                report($sformatf("read_attr %h, expected %h", at, want.read_attr));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    tcw_in_if  in_ch ();
    tcw_out_if out_ch ();

    console_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int attr_settings;

    text_console_writer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.cursor_offset, out_ch.read_char, out_ch.read_attr);
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task send_item(logic [OPCODE_W-1:0] op, logic [CHAR_W-1:0] ch, logic [INDEX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= op;
        in_ch.char_code  <= ch;
        in_ch.cell_index <= idx;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(op, ch, idx);
    endtask

    task put_char(logic [CHAR_W-1:0] ch);
        send_item(OP_PUT, ch, INDEX_W'($urandom_range(INDEX_MAX)));
    endtask

    task read_cell(int idx);
        send_item(OP_READ, CHAR_W'($urandom_range(255)), INDEX_W'(idx));
    endtask

    task settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task set_text_attr(logic [ATTR_W-1:0] value);
        logic [APB_DATA_W-1:0] back;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TEXT_ATTR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        back = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (back !== APB_DATA_W'(value))
            sb.report($sformatf("text_attr reads back %h, expected %h", back, value));
        sb.attr = value;
        attr_settings++;
    endtask

    task run_directed();
        read_cell(0);
        read_cell(CELLS - 1);
        read_cell(CELLS);
        read_cell(INDEX_MAX);
        put_char(CH_BACKSPACE);
        read_cell(0);
        put_char(8'hFF);
        put_char(CH_NUL);
        put_char(CH_TAB);
        put_char(CH_RETURN);
        put_char(CH_NEWLINE);
        put_char(CH_BACKSPACE);
        read_cell(COLS - 1);
        put_char(CH_TAB);
        put_char(8'h41);
        read_cell(COLS);
        send_item(OP_UNUSED, 8'hFF, INDEX_W'(INDEX_MAX));
        send_item(OP_CLEAR, 8'hAA, 11'h555);
        read_cell(0);
        read_cell(COLS);
    endtask

    task run_random(int target, bit pause_midway);
        int sent;
        int kind;
        int len;
        int pick;
        int here;
        logic [CHAR_W-1:0] ch;
        sent = 0;
        while (sent < target) begin
            kind = $urandom_range(99);
            if (kind < 1) begin
                send_item(OP_CLEAR, CHAR_W'($urandom_range(255)),
                          INDEX_W'($urandom_range(INDEX_MAX)));
                sent++;
            end else if (kind < 6) begin
                len = $urandom_range(1, 6);
                repeat (len) put_char(CH_NEWLINE);
                sent += len;
            end else begin
                pick = $urandom_range(99);
                if (pick < 70)
                    len = $urandom_range(0, 10);
                else if (pick < 95)
                    len = $urandom_range(11, COLS - 1);
                else
                    len = $urandom_range(COLS, 2 * COLS + 10);
                for (int i = 0; i < len; i++) begin
                    pick = $urandom_range(99);
                    if (pick < 20) begin
                        here = sb.cursor();
                        pick = $urandom_range(99);
                        if (pick < 50)
                            read_cell($urandom_range(CELLS - 1));
                        else if (pick < 80)
                            read_cell(here >= 2 ? here - 2 + $urandom_range(4)
                                                : $urandom_range(4));
                        else
                            read_cell($urandom_range(INDEX_MAX));
                        sent++;
                    end else if (pick < 21) begin
                        send_item(OP_UNUSED, CHAR_W'($urandom_range(255)),
                                  INDEX_W'($urandom_range(INDEX_MAX)));
                        sent++;
                    end
                    pick = $urandom_range(99);
                    if (pick < 85) begin
                        ch = CHAR_W'($urandom_range(8'h20, 8'h7E));
                    end else if (pick < 93) begin
                        case ($urandom_range(2))
                            0: ch = CH_BACKSPACE;
                            1: ch = CH_TAB;
                            default: ch = CH_RETURN;
                        endcase
                    end else begin
                        ch = CHAR_W'($urandom_range(255));
                    end
                    put_char(ch);
                    sent++;
                end
                pick = $urandom_range(99);
                if (pick < 80) begin
                    put_char(CH_NEWLINE);
                    sent++;
                end else if (pick < 90) begin
                    put_char(CH_RETURN);
                    sent++;
                end
            end
            if (pause_midway && sent >= target / 2) begin
                settle();
                pause_midway = 1'b0;
            end
        end
    endtask

    initial begin
        sb = new();
        attr_settings     = 0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.opcode      = OP_PUT;
        in_ch.char_code   = '0;
        in_ch.cell_index  = '0;
        out_ch.ready      = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        settle();
        set_text_attr(8'h00);
        send_idle_pct = 23;
        recv_idle_pct = 86;
        run_random(PHASE_ITEMS, 1'b1);

        settle();
        set_text_attr(8'hFF);
        send_idle_pct = 86;
        recv_idle_pct = 23;
        run_random(PHASE_ITEMS, 1'b0);

        settle();
        set_text_attr(ATTR_W'($urandom_range(1, 254)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS, 1'b0);

        settle();
        repeat (CELLS + 64) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        $display("Covered %0d commands: %0d puts, %0d reads, %0d clears, %0d unused opcodes.",
                 sb.puts + sb.reads + sb.clears + sb.unused, sb.puts, sb.reads, sb.clears,
                 sb.unused);
        $display("The screen scrolled %0d times across %0d attribute settings.",
                 sb.scrolls, attr_settings);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
sv/tcw_pkg.sv
sv/tcw_in_if.sv
sv/tcw_out_if.sv
sv/tcw_front.sv
sv/tcw_queue.sv
sv/tcw_back.sv
sv/text_console_writer_core.sv
tb/sv/text_console_writer_core_tb.sv
